FILE: sv/looping_segment_envelope_player_defines.svh
// assertion macros shared by the envelope player modules
`ifndef LOOPING_SEGMENT_ENVELOPE_PLAYER_DEFINES_SVH
`define LOOPING_SEGMENT_ENVELOPE_PLAYER_DEFINES_SVH

// same-cycle implication, off during reset
`define LSEP_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LSEP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lsep_pkg.sv
package lsep_pkg;

    localparam int SEGMENTS   = 16;
    localparam int PHASE_BITS = 24;

    localparam int SEG_W      = $clog2(SEGMENTS);
    localparam int HA_W       = $clog2(SEGMENTS + 1);
    localparam int HIDX_W     = 5;
    localparam int POS_W      = 25;
    localparam int SUM_W      = POS_W + 1;
    localparam int INC_W      = 24;
    localparam int LVL_W      = 16;
    localparam int OUT_LVL_W  = 21;
    localparam int AMAX_W     = 20;
    localparam int KIND_W     = 2;
    localparam int MODE_W     = 3;
    localparam int STATE_W    = 3;
    localparam int RANGE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [POS_W-1:0] FULL      = POS_W'(64'd1 << PHASE_BITS);
    localparam logic [POS_W-1:0] FULL_MASK = FULL - POS_W'(1);
    localparam logic [SUM_W-1:0] FULL_S    = SUM_W'(64'd1 << PHASE_BITS);
    localparam logic [SUM_W-1:0] TWO_FULL  = SUM_W'(64'd2 << PHASE_BITS);

    localparam logic [LVL_W-1:0]  HANDLE_RST = LVL_W'(32768);
    localparam logic [INC_W-1:0]  INC_RST    = INC_W'(65536);
    localparam logic [AMAX_W-1:0] AMAX_RST   = AMAX_W'(327680);
    localparam logic [AMAX_W-1:0] PEAK_5     = AMAX_W'(5 * 65536);
    localparam logic [AMAX_W-1:0] PEAK_10    = AMAX_W'(10 * 65536);
    localparam logic [AMAX_W-1:0] PEAK_1     = AMAX_W'(65536);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_MODE  = 2'd2
    } t_kind;

    typedef enum logic [MODE_W-1:0] {
        MD_LOOP     = 3'd0,
        MD_REVERSE  = 3'd1,
        MD_ONESHOT  = 3'd2,
        MD_TWOSHOT  = 3'd3,
        MD_PINGPONG = 3'd4
    } t_mode;

    typedef enum logic [STATE_W-1:0] {
        ST_RUN      = 3'd0,
        ST_RUN_REV  = 3'd1,
        ST_WAIT     = 3'd2,
        ST_WAIT_REV = 3'd3,
        ST_HOLD     = 3'd4
    } t_play_state;

    typedef enum logic [RANGE_W-1:0] {
        RNG_UNI5  = 3'd0,
        RNG_BI5   = 3'd1,
        RNG_UNI10 = 3'd2,
        RNG_BI10  = 3'd3,
        RNG_UNI1  = 3'd4,
        RNG_BI1   = 3'd5,
        RNG_AUDIO = 3'd6
    } t_range;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC = 2'd0,
        CFG_RANGE     = 2'd1,
        CFG_GATE      = 2'd2,
        CFG_AUDIO_MAX = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic capture;
        logic update;
        logic read;
        logic interp;
        logic level;
        logic scale;
        logic div;
        logic load;
    } t_cmd;

endpackage

FILE: sv/lsep_if.sv
interface lsep_item_if;
    logic                             valid;
    logic                             ready;
    logic [lsep_pkg::KIND_W-1:0]      kind;
    logic                             trig;
    logic                             hold;
    logic [lsep_pkg::HIDX_W-1:0]      handle_index;
    logic [lsep_pkg::LVL_W-1:0]       handle_level;
    logic [lsep_pkg::MODE_W-1:0]      new_mode;

    modport source (output valid, kind, trig, hold, handle_index, handle_level, new_mode,
                    input ready);
    modport sink   (input valid, kind, trig, hold, handle_index, handle_level, new_mode,
                    output ready);
endinterface

interface lsep_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [lsep_pkg::OUT_LVL_W-1:0] level;
    logic [lsep_pkg::POS_W-1:0]          position;
    logic [lsep_pkg::STATE_W-1:0]        play_state_out;
    logic [lsep_pkg::SEG_W-1:0]          segment;

    modport source (output valid, level, position, play_state_out, segment, input ready);
    modport sink   (input valid, level, position, play_state_out, segment, output ready);
endinterface

interface lsep_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [lsep_pkg::CFG_IDX_W-1:0]    index;
    logic [lsep_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/looping_segment_envelope_player.sv
// channel   dir  handshake        payload
// i_item    in   valid / ready    kind trig hold handle_index handle_level new_mode
// i_cfg     in   valid / ready    index data (ready always high)
// o_result  out  valid / ready    level position play_state_out segment
//
// one item at a time: an accepted item passes the update, read, interp, level, scale and div
// states, then out loads the output register, and the next item is accepted back in idle
// the serial chain is update, handle read, interpolation multiply,
// range multiply and a two-step divide by 65535
// synchronous active-low reset; handle levels read as half until written, no clearing pass
// a result waiting in the output register stalls the last step only

module looping_segment_envelope_player (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsep_item_if.sink     i_item,
    lsep_cfg_if.sink      i_cfg,
    lsep_result_if.source o_result
);

    lsep_pkg::t_cmd cmd;
    logic           in_ready;
    logic           out_valid;

    assign i_cfg.ready    = 1'b1;
    assign i_item.ready   = in_ready;
    assign o_result.valid = out_valid;

    lsep_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd)
    );

    lsep_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_kind         (i_item.kind),
        .i_trig         (i_item.trig),
        .i_hold         (i_item.hold),
        .i_handle_index (i_item.handle_index),
        .i_handle_level (i_item.handle_level),
        .i_new_mode     (i_item.new_mode),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_level        (o_result.level),
        .o_position     (o_result.position),
        .o_play_state   (o_result.play_state_out),
        .o_segment      (o_result.segment)
    );

endmodule

FILE: sv/lsep_ctrl.sv
`include "looping_segment_envelope_player_defines.svh"

module lsep_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output lsep_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_READ,
        S_INTERP,
        S_LEVEL,
        S_SCALE,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_INTERP;
            end
            S_INTERP: begin
                o_cmd.interp = 1'b1;
                n_state      = S_LEVEL;
            end
            S_LEVEL: begin
                o_cmd.level = 1'b1;
                n_state     = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // wait for room in the output register
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `LSEP_ASSERT(a_load_has_room, i_clk, i_rst_n, o_cmd.load, !r_out_valid || i_out_ready, "result loaded over an untaken item")
    `LSEP_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, o_cmd.load, r_out_valid, "loaded result not presented")
    `LSEP_ASSERT_NEXT(a_accept_updates, i_clk, i_rst_n, i_in_valid && o_in_ready, o_cmd.update, "accepted item not processed")

endmodule

FILE: sv/lsep_dp.sv
`include "looping_segment_envelope_player_defines.svh"

module lsep_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  lsep_pkg::t_cmd                        i_cmd,
    input  logic [lsep_pkg::KIND_W-1:0]           i_kind,
    input  logic                                  i_trig,
    input  logic                                  i_hold,
    input  logic [lsep_pkg::HIDX_W-1:0]           i_handle_index,
    input  logic [lsep_pkg::LVL_W-1:0]            i_handle_level,
    input  logic [lsep_pkg::MODE_W-1:0]           i_new_mode,
    input  logic                                  i_cfg_we,
    input  logic [lsep_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [lsep_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic signed [lsep_pkg::OUT_LVL_W-1:0] o_level,
    output logic [lsep_pkg::POS_W-1:0]            o_position,
    output logic [lsep_pkg::STATE_W-1:0]          o_play_state,
    output logic [lsep_pkg::SEG_W-1:0]            o_segment
);

    localparam int SC_W   = lsep_pkg::POS_W + lsep_pkg::SEG_W + 1;
    localparam int F_W    = lsep_pkg::PHASE_BITS + 1;
    localparam int PROD_W = lsep_pkg::LVL_W + 1 + F_W + 1;
    localparam int STEP_W = lsep_pkg::LVL_W + 2;
    localparam int NUM_W  = lsep_pkg::LVL_W + lsep_pkg::AMAX_W;
    localparam int X_W    = NUM_W + 1;
    localparam int QA_W   = X_W - lsep_pkg::LVL_W;
    localparam int QS_W   = QA_W + 1;
    localparam int A2_W   = QS_W - lsep_pkg::LVL_W;
    localparam logic signed [STEP_W-1:0] BI_OFS   = STEP_W'((1 << lsep_pkg::LVL_W) - 1);
    localparam logic [lsep_pkg::LVL_W:0] LVL_MAX  = (lsep_pkg::LVL_W + 1)'((1 << lsep_pkg::LVL_W) - 1);
    localparam logic [X_W-1:0]           RND_HALF = X_W'((1 << (lsep_pkg::LVL_W - 1)) - 1);

    // configuration
    logic [lsep_pkg::INC_W-1:0]   r_phase_inc;
    logic [lsep_pkg::RANGE_W-1:0] r_range;
    logic                         r_gate;
    logic [lsep_pkg::AMAX_W-1:0]  r_audio_max;

    // captured item
    logic [lsep_pkg::KIND_W-1:0]  r_kind;
    logic                         r_trig;
    logic                         r_hold;
    logic [lsep_pkg::HIDX_W-1:0]  r_hidx;
    logic [lsep_pkg::LVL_W-1:0]   r_hlvl;
    logic [lsep_pkg::MODE_W-1:0]  r_new_mode;

    // player state
    logic [lsep_pkg::POS_W-1:0]   r_pos;
    logic [lsep_pkg::POS_W-1:0]   n_pos;
    lsep_pkg::t_play_state        r_state;
    lsep_pkg::t_play_state        n_state;
    lsep_pkg::t_play_state        r_saved;
    lsep_pkg::t_play_state        n_saved;
    lsep_pkg::t_mode              r_mode;
    lsep_pkg::t_mode              n_mode;
    logic                         hwe;
    logic                         mode_ok;

    // handle store
    logic [lsep_pkg::LVL_W-1:0]   r_handle_mem [0:lsep_pkg::SEGMENTS];
    logic [lsep_pkg::SEGMENTS:0]  r_handle_vld;

    // phase arithmetic
    logic [lsep_pkg::POS_W-1:0]   inc_ext;
    logic [lsep_pkg::SUM_W-1:0]   fwd_sum;
    logic [lsep_pkg::POS_W-1:0]   under;

    // segment lookup
    logic [SC_W-1:0]              scaled;
    logic [SC_W-1:0]              seg_raw;
    logic [lsep_pkg::SEG_W-1:0]   seg_c;
    logic [SC_W-1:0]              f_raw;
    logic [F_W-1:0]               f_c;
    logic [lsep_pkg::HA_W-1:0]    addr0;
    logic [lsep_pkg::HA_W-1:0]    addr1;

    // level pipeline
    logic [lsep_pkg::SEG_W-1:0]   r_seg;
    logic [F_W-1:0]               r_f;
    logic [lsep_pkg::LVL_W-1:0]   r_h0;
    logic [lsep_pkg::LVL_W-1:0]   r_h1;
    logic signed [lsep_pkg::LVL_W:0] diff;
    logic signed [F_W:0]          f_s;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [STEP_W-1:0]     step;
    logic signed [STEP_W-1:0]     y_s;
    logic [lsep_pkg::LVL_W-1:0]   y;
    logic signed [STEP_W-1:0]     v;
    logic [lsep_pkg::LVL_W-1:0]   r_mag;
    logic                         r_neg;
    logic [lsep_pkg::AMAX_W-1:0]  peak;
    logic                         bipolar;
    logic [NUM_W-1:0]             r_num;
    logic [X_W-1:0]               x;
    logic [QA_W-1:0]              r_qa;
    logic [QS_W-1:0]              r_qs;
    logic [A2_W-1:0]              a2;
    logic [lsep_pkg::LVL_W:0]     t2;
    logic [lsep_pkg::OUT_LVL_W-1:0] q;
    logic [lsep_pkg::OUT_LVL_W-1:0] level_c;

    // output register
    logic [lsep_pkg::OUT_LVL_W-1:0] r_out_level;
    logic [lsep_pkg::POS_W-1:0]     r_out_pos;
    logic [lsep_pkg::STATE_W-1:0]   r_out_state;
    logic [lsep_pkg::SEG_W-1:0]     r_out_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= lsep_pkg::INC_RST;
            r_range     <= lsep_pkg::RNG_UNI5;
            r_gate      <= 1'b0;
            r_audio_max <= lsep_pkg::AMAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lsep_pkg::CFG_PHASE_INC: r_phase_inc <= i_cfg_data[lsep_pkg::INC_W-1:0];
                lsep_pkg::CFG_RANGE:     r_range     <= i_cfg_data[lsep_pkg::RANGE_W-1:0];
                lsep_pkg::CFG_GATE:      r_gate      <= i_cfg_data[0];
                lsep_pkg::CFG_AUDIO_MAX: r_audio_max <= i_cfg_data[lsep_pkg::AMAX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind     <= i_kind;
            r_trig     <= i_trig;
            r_hold     <= i_hold;
            r_hidx     <= i_handle_index;
            r_hlvl     <= i_handle_level;
            r_new_mode <= i_new_mode;
        end
    end

    assign inc_ext = lsep_pkg::POS_W'(r_phase_inc);
    assign fwd_sum = lsep_pkg::SUM_W'(r_pos) + lsep_pkg::SUM_W'(r_phase_inc);
    assign under   = inc_ext - r_pos;

    always_comb begin
        n_pos   = r_pos;
        n_state = r_state;
        n_saved = r_saved;
        n_mode  = r_mode;
        hwe     = 1'b0;
        mode_ok = 1'b0;
        if (i_cmd.update) begin
            case (r_kind)
                lsep_pkg::KIND_TICK: begin
                    case (r_state) inside
                        lsep_pkg::ST_RUN, lsep_pkg::ST_RUN_REV: begin
                            if (r_hold) begin
                                n_saved = r_state;
                                n_state = lsep_pkg::ST_HOLD;
                            end else if (r_state == lsep_pkg::ST_RUN_REV) begin
                                if (r_pos > inc_ext) begin
                                    n_pos = r_pos - inc_ext;
                                end else if (r_mode == lsep_pkg::MD_TWOSHOT) begin
                                    n_pos   = '0;
                                    n_state = lsep_pkg::ST_WAIT;
                                end else if (r_mode == lsep_pkg::MD_PINGPONG) begin
                                    n_pos   = (under > lsep_pkg::FULL) ? lsep_pkg::FULL : under;
                                    n_state = lsep_pkg::ST_RUN;
                                end else if (under <= lsep_pkg::FULL) begin
                                    n_pos = lsep_pkg::FULL - under;
                                end else begin
                                    n_pos = (lsep_pkg::FULL - (under & lsep_pkg::FULL_MASK))
                                            & lsep_pkg::FULL_MASK;
                                end
                            end else if (fwd_sum >= lsep_pkg::FULL_S) begin
                                if (r_mode == lsep_pkg::MD_ONESHOT) begin
                                    n_pos   = lsep_pkg::FULL_MASK;
                                    n_state = lsep_pkg::ST_WAIT;
                                end else if (r_mode == lsep_pkg::MD_TWOSHOT) begin
                                    n_pos   = lsep_pkg::FULL_MASK;
                                    n_state = lsep_pkg::ST_WAIT_REV;
                                end else if (r_mode == lsep_pkg::MD_PINGPONG) begin
                                    n_pos   = (fwd_sum > lsep_pkg::TWO_FULL) ? '0 :
                                              lsep_pkg::POS_W'(lsep_pkg::TWO_FULL - fwd_sum);
                                    n_state = lsep_pkg::ST_RUN_REV;
                                end else begin
                                    n_pos = fwd_sum[lsep_pkg::POS_W-1:0] & lsep_pkg::FULL_MASK;
                                end
                            end else begin
                                n_pos = fwd_sum[lsep_pkg::POS_W-1:0];
                            end
                        end
                        lsep_pkg::ST_WAIT: begin
                            if (r_trig) begin
                                n_pos   = '0;
                                n_state = lsep_pkg::ST_RUN;
                            end
                        end
                        lsep_pkg::ST_WAIT_REV: begin
                            if (r_trig) begin
                                n_pos   = lsep_pkg::FULL;
                                n_state = lsep_pkg::ST_RUN_REV;
                            end
                        end
                        default: begin
                            if (!r_hold) begin
                                n_state = r_saved;
                            end
                        end
                    endcase
                end
                lsep_pkg::KIND_WRITE: begin
                    hwe = (32'(r_hidx) <= 32'(lsep_pkg::SEGMENTS));
                end
                lsep_pkg::KIND_MODE: begin
                    mode_ok = 1'b1;
                    case (r_new_mode) inside
                        lsep_pkg::MD_LOOP:    n_state = lsep_pkg::ST_RUN;
                        lsep_pkg::MD_REVERSE: n_state = lsep_pkg::ST_RUN_REV;
                        lsep_pkg::MD_ONESHOT, lsep_pkg::MD_TWOSHOT: begin
                            n_pos   = '0;
                            n_state = lsep_pkg::ST_WAIT;
                        end
                        lsep_pkg::MD_PINGPONG: begin
                            if (r_state == lsep_pkg::ST_WAIT) begin
                                n_state = lsep_pkg::ST_RUN;
                            end else if (r_state == lsep_pkg::ST_WAIT_REV) begin
                                n_state = lsep_pkg::ST_RUN_REV;
                            end
                        end
                        default: mode_ok = 1'b0;
                    endcase
                    if (mode_ok) begin
                        n_saved = n_state;
                        n_mode  = lsep_pkg::t_mode'(r_new_mode);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_state      <= lsep_pkg::ST_RUN;
            r_saved      <= lsep_pkg::ST_RUN;
            r_mode       <= lsep_pkg::MD_LOOP;
            r_handle_vld <= '0;
        end else begin
            r_pos   <= n_pos;
            r_state <= n_state;
            r_saved <= n_saved;
            r_mode  <= n_mode;
            if (hwe) begin
                r_handle_vld[r_hidx[lsep_pkg::HA_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (hwe) begin
            r_handle_mem[r_hidx[lsep_pkg::HA_W-1:0]] <= r_hlvl;
        end
    end

    // segment and fraction, last segment takes the full-cycle position
    assign scaled  = SC_W'(r_pos) * SC_W'(lsep_pkg::SEGMENTS);
    assign seg_raw = scaled >> lsep_pkg::PHASE_BITS;
    assign seg_c   = (seg_raw > SC_W'(lsep_pkg::SEGMENTS - 1)) ?
                     lsep_pkg::SEG_W'(lsep_pkg::SEGMENTS - 1) : seg_raw[lsep_pkg::SEG_W-1:0];
    assign f_raw   = scaled - (SC_W'(seg_c) << lsep_pkg::PHASE_BITS);
    assign f_c     = (f_raw > SC_W'(lsep_pkg::FULL)) ? F_W'(lsep_pkg::FULL) : f_raw[F_W-1:0];
    assign addr0   = lsep_pkg::HA_W'(seg_c);
    assign addr1   = lsep_pkg::HA_W'(seg_c) + lsep_pkg::HA_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_seg <= seg_c;
            r_f   <= f_c;
            r_h0  <= r_handle_vld[addr0] ? r_handle_mem[addr0] : lsep_pkg::HANDLE_RST;
            r_h1  <= r_handle_vld[addr1] ? r_handle_mem[addr1] : lsep_pkg::HANDLE_RST;
        end
    end

    // y = h0 + floor((h1 - h0) * f / FULL)
    assign diff = $signed({1'b0, r_h1}) - $signed({1'b0, r_h0});
    assign f_s  = $signed({1'b0, r_f});

    always_ff @(posedge i_clk) begin
        if (i_cmd.interp) begin
            r_prod <= diff * f_s;
        end
    end

    always_comb begin
        peak    = '0;
        bipolar = r_range[0];
        case (r_range) inside
            lsep_pkg::RNG_UNI5, lsep_pkg::RNG_BI5:   peak = lsep_pkg::PEAK_5;
            lsep_pkg::RNG_UNI10, lsep_pkg::RNG_BI10: peak = lsep_pkg::PEAK_10;
            lsep_pkg::RNG_UNI1, lsep_pkg::RNG_BI1:   peak = lsep_pkg::PEAK_1;
            lsep_pkg::RNG_AUDIO: begin
                peak    = r_audio_max;
                bipolar = 1'b1;
            end
            default: peak = '0;
        endcase
    end

    assign step = STEP_W'(r_prod >>> lsep_pkg::PHASE_BITS);
    assign y_s  = $signed({2'b00, r_h0}) + step;
    assign y    = r_gate ? r_h0 : y_s[lsep_pkg::LVL_W-1:0];
    assign v    = bipolar ? ($signed({1'b0, y, 1'b0}) - BI_OFS) : $signed({2'b00, y});

    always_ff @(posedge i_clk) begin
        if (i_cmd.level) begin
            r_neg <= v[STEP_W-1];
            r_mag <= v[STEP_W-1] ? lsep_pkg::LVL_W'(-v) : lsep_pkg::LVL_W'(v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_num <= NUM_W'(r_mag) * NUM_W'(peak);
        end
    end

    // rounded divide by 65535: x = a*65535 + (a + b), folded twice
    assign x = X_W'(r_num) + RND_HALF;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div) begin
            r_qa <= x[X_W-1:lsep_pkg::LVL_W];
            r_qs <= QS_W'(x[X_W-1:lsep_pkg::LVL_W]) + QS_W'(x[lsep_pkg::LVL_W-1:0]);
        end
    end

    assign a2      = r_qs[QS_W-1:lsep_pkg::LVL_W];
    assign t2      = (lsep_pkg::LVL_W + 1)'(a2) + (lsep_pkg::LVL_W + 1)'(r_qs[lsep_pkg::LVL_W-1:0]);
    assign q       = lsep_pkg::OUT_LVL_W'(r_qa) + lsep_pkg::OUT_LVL_W'(a2)
                     + lsep_pkg::OUT_LVL_W'(t2 >= LVL_MAX);
    assign level_c = r_neg ? (-q) : q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_level <= level_c;
            r_out_pos   <= r_pos;
            r_out_state <= r_state;
            r_out_seg   <= r_seg;
        end
    end

    assign o_level      = $signed(r_out_level);
    assign o_position   = r_out_pos;
    assign o_play_state = r_out_state;
    assign o_segment    = r_out_seg;

    `LSEP_ASSERT(a_pos_in_cycle, i_clk, i_rst_n, 1'b1, r_pos <= lsep_pkg::FULL, "position beyond one cycle")
    `LSEP_ASSERT(a_wait_parked, i_clk, i_rst_n, r_state == lsep_pkg::ST_WAIT, r_pos == '0 || r_pos == lsep_pkg::FULL_MASK, "waiting away from a parking point")

endmodule
